[rtl/uer_pkg.sv]
package uer_pkg;

  localparam int unsigned HdrBytes  = 46;
  localparam int unsigned PosW      = 6;
  localparam int unsigned QDepth    = 4;
  localparam int unsigned QPtrW     = 2;
  localparam int unsigned AccW      = 20;

  localparam logic [PosW-1:0] HdrLastPos  = 6'd45;
  localparam logic [PosW-1:0] HdrFull     = 6'd46;
  localparam logic [PosW-1:0] ProtoPos    = 6'd23;
  localparam logic [PosW-1:0] IpSumPos    = 6'd24;
  localparam logic [PosW-1:0] IpHdrFirst  = 6'd14;
  localparam logic [PosW-1:0] IpHdrLast   = 6'd33;
  localparam logic [PosW-1:0] UdpSumPos   = 6'd40;
  localparam logic [PosW-1:0] TagPos      = 6'd42;
  localparam logic [7:0]      ProtoUdp    = 8'h11;

  localparam logic [31:0] TagEcho = 32'h4543_484F;  // "ECHO"
  localparam logic [31:0] TagHash = 32'h4841_5348;  // "HASH"
  localparam logic [31:0] TagFlow = 32'h464C_4F57;  // "FLOW"
  localparam logic [31:0] TagSequ = 32'h5345_5155;  // "SEQU"

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_SEND
  } back_state_t;

  // One queue entry: either a single pass-through byte or a header release
  typedef struct packed {
    logic            is_hdr;
    logic [7:0]      data;
    logic            last;
    logic [PosW-1:0] count;
    logic            echo;
    logic [15:0]     csum;
  } cmd_t;

  // Header store write port
  typedef struct packed {
    logic            en;
    logic [PosW-1:0] addr;
    logic [7:0]      data;
  } wr_t;

  // Store address of the byte released at position idx of an echo header
  function automatic logic [PosW-1:0] map_addr(input logic [PosW-1:0] idx,
                                               input logic echo);
    logic [PosW-1:0] a;
    a = idx;
    if (echo) begin
      if (idx <= 6'd5) a = 6'(idx + 6'd6);
      else if (idx <= 6'd11) a = 6'(idx - 6'd6);
      else if (idx >= 6'd26 && idx <= 6'd29) a = 6'(idx + 6'd4);
      else if (idx >= 6'd30 && idx <= 6'd33) a = 6'(idx - 6'd4);
      else if (idx == 6'd34 || idx == 6'd35) a = 6'(idx + 6'd2);
      else if (idx == 6'd36 || idx == 6'd37) a = 6'(idx - 6'd2);
    end
    return a;
  endfunction

endpackage

[rtl/uer_front.sv]
module uer_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [7:0]       in_byte,
  input  logic             in_last,
  output logic             in_ready,
  input  logic             q_full,
  input  logic             rel_done,
  output logic             push,
  output uer_pkg::cmd_t    push_cmd,
  output uer_pkg::wr_t     wr
);

  logic [uer_pkg::PosW-1:0] pos;
  logic [uer_pkg::AccW-1:0] acc;
  logic [uer_pkg::AccW-1:0] acc_next;
  logic [7:0]               proto;
  logic [23:0]              tag;
  logic                     outstanding;
  logic                     accept;
  logic                     in_hdr;
  logic                     sum_byte;
  logic                     echo;
  logic [16:0]              fold1;
  logic [16:0]              fold2;
  logic [31:0]              tag_full;

  assign in_hdr   = (pos < uer_pkg::HdrFull);
  assign in_ready = !q_full && (!in_hdr || !outstanding);
  assign accept   = in_valid && in_ready;

  // Select bytes 14..33 of the IP header, skipping its checksum field
  assign sum_byte = (pos >= uer_pkg::IpHdrFirst) && (pos <= uer_pkg::IpHdrLast) &&
                    (pos != uer_pkg::IpSumPos) &&
                    (pos != 6'(uer_pkg::IpSumPos + 6'd1));

  always_comb begin
    acc_next = acc;
    if (sum_byte) begin
      if (pos[0]) acc_next = acc + uer_pkg::AccW'(in_byte);
      else acc_next = acc + uer_pkg::AccW'({in_byte, 8'h00});
    end
  end

  // Fold the ones'-complement sum to 16 bits
  assign fold1 = 17'(acc[uer_pkg::AccW-1:16]) + 17'(acc[15:0]);
  assign fold2 = 17'(fold1[15:0]) + 17'(fold1[16]);

  // Classify on the last header byte
  assign tag_full = {tag, in_byte};
  assign echo = (proto == uer_pkg::ProtoUdp) &&
                (tag_full == uer_pkg::TagEcho || tag_full == uer_pkg::TagHash ||
                 tag_full == uer_pkg::TagFlow || tag_full == uer_pkg::TagSequ);

  // Build the queue command and the store write
  always_comb begin
    push           = 1'b0;
    push_cmd       = '0;
    push_cmd.data  = in_byte;
    push_cmd.last  = in_last;
    push_cmd.csum  = ~fold2[15:0];
    wr.en          = accept && in_hdr;
    wr.addr        = pos;
    wr.data        = in_byte;
    if (accept) begin
      if (!in_hdr) begin
        push = 1'b1;
      end else if (pos == uer_pkg::HdrLastPos) begin
        push            = 1'b1;
        push_cmd.is_hdr = 1'b1;
        push_cmd.count  = uer_pkg::HdrFull;
        push_cmd.echo   = echo;
      end else if (in_last) begin
        push            = 1'b1;
        push_cmd.is_hdr = 1'b1;
        push_cmd.count  = 6'(pos + 6'd1);
      end
    end
  end

  // Track position, checksum and classification fields
  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      acc         <= '0;
      outstanding <= 1'b0;
    end else begin
      if (accept) begin
        if (in_last) pos <= '0;
        else if (in_hdr) pos <= 6'(pos + 6'd1);
        if (in_hdr) begin
          if (pos == '0) acc <= '0;
          else acc <= acc_next;
        end
      end
      if (push && push_cmd.is_hdr) outstanding <= 1'b1;
      else if (rel_done) outstanding <= 1'b0;
    end
  end

  // Capture protocol and tag bytes
  always_ff @(posedge clk) begin
    if (accept && pos == uer_pkg::ProtoPos) proto <= in_byte;
    if (accept && pos == uer_pkg::TagPos) tag[23:16] <= in_byte;
    if (accept && pos == 6'(uer_pkg::TagPos + 6'd1)) tag[15:8] <= in_byte;
    if (accept && pos == 6'(uer_pkg::TagPos + 6'd2)) tag[7:0] <= in_byte;
  end

endmodule

[rtl/uer_queue.sv]
module uer_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  uer_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output uer_pkg::cmd_t head
);

  uer_pkg::cmd_t             slots [uer_pkg::QDepth];
  logic [uer_pkg::QPtrW-1:0] wptr;
  logic [uer_pkg::QPtrW-1:0] rptr;
  logic [uer_pkg::QPtrW:0]   fill;

  assign full       = (fill == (uer_pkg::QPtrW+1)'(uer_pkg::QDepth));
  assign head_valid = (fill != '0);
  assign head       = slots[rptr];

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      if (push && !pop) fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

  // Hold entries
  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_cmd;
  end

endmodule

[rtl/uer_back.sv]
module uer_back (
  input  logic          clk,
  input  logic          rst,
  input  uer_pkg::wr_t  wr,
  input  logic          head_valid,
  input  uer_pkg::cmd_t head,
  output logic          pop,
  output logic          rel_done,
  output logic          out_valid,
  output logic [7:0]    out_byte,
  output logic          out_last,
  input  logic          out_ready
);

  uer_pkg::back_state_t     state;
  uer_pkg::back_state_t     state_next;
  logic [7:0]               store [uer_pkg::HdrBytes];
  logic [7:0]               rdata;
  logic [uer_pkg::PosW-1:0] idx;
  logic [uer_pkg::PosW-1:0] idx_plus;
  logic                     slot_free;
  logic                     at_end;
  logic                     ren;
  logic [uer_pkg::PosW-1:0] raddr;
  logic                     load;
  logic [7:0]               load_byte;
  logic                     load_last;
  logic                     step;

  assign slot_free = !out_valid || out_ready;
  assign idx_plus  = 6'(idx + 6'd1);
  assign at_end    = (idx == 6'(head.count - 6'd1));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      uer_pkg::BK_IDLE: begin
        if (head_valid && head.is_hdr) state_next = uer_pkg::BK_FETCH;
      end
      uer_pkg::BK_FETCH: begin
        state_next = uer_pkg::BK_SEND;
      end
      uer_pkg::BK_SEND: begin
        if (slot_free && at_end) state_next = uer_pkg::BK_IDLE;
      end
      default: state_next = uer_pkg::BK_IDLE;
    endcase
  end

  // Substitute rewritten fields of an echo header
  function automatic logic [7:0] subst(input logic [uer_pkg::PosW-1:0] i,
                                       input logic [7:0] d,
                                       input uer_pkg::cmd_t c);
    logic [7:0] r;
    r = d;
    if (c.echo) begin
      if (i == uer_pkg::IpSumPos) r = c.csum[15:8];
      else if (i == 6'(uer_pkg::IpSumPos + 6'd1)) r = c.csum[7:0];
      else if (i == uer_pkg::UdpSumPos || i == 6'(uer_pkg::UdpSumPos + 6'd1)) r = 8'h00;
    end
    return r;
  endfunction

  // Outputs of each state
  always_comb begin
    pop       = 1'b0;
    rel_done  = 1'b0;
    ren       = 1'b0;
    raddr     = uer_pkg::map_addr(idx, head.echo);
    load      = 1'b0;
    load_byte = head.data;
    load_last = head.last;
    step      = 1'b0;
    unique case (state)
      uer_pkg::BK_IDLE: begin
        if (head_valid && !head.is_hdr && slot_free) begin
          load = 1'b1;
          pop  = 1'b1;
        end
      end
      uer_pkg::BK_FETCH: begin
        ren = 1'b1;
      end
      uer_pkg::BK_SEND: begin
        load_byte = subst(idx, rdata, head);
        load_last = head.last && at_end;
        if (slot_free) begin
          load = 1'b1;
          if (at_end) begin
            pop      = 1'b1;
            rel_done = 1'b1;
          end else begin
            ren   = 1'b1;
            raddr = uer_pkg::map_addr(idx_plus, head.echo);
            step  = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // State and release index
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= uer_pkg::BK_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == uer_pkg::BK_IDLE) idx <= '0;
      else if (step) idx <= idx_plus;
      if (load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= load_byte;
      out_last <= load_last;
    end
  end

  // Header store: written by the front, read here
  always_ff @(posedge clk) begin
    if (wr.en) store[wr.addr] <= wr.data;
    if (ren) rdata <= store[raddr];
  end

endmodule

[rtl/udp_echo_reflector_top.sv]
// Path: a pass-through byte is held in the command queue, then in the output register; a
// held header is queued at its 46th byte (or the last byte of a short frame), then read.
// Throughput: one byte per cycle in and out unless the queue or receiver stalls; a header
// release idles the output while the store is read, and the next header waits for its end.
// Reset: rst is synchronous and active high; it empties the command queue and the
// output register and returns to the start of a frame. The header store is not cleared.
module udp_echo_reflector_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic          q_full;
  logic          push;
  uer_pkg::cmd_t push_cmd;
  uer_pkg::wr_t  wr;
  logic          rel_done;
  logic          pop;
  logic          head_valid;
  uer_pkg::cmd_t head;

  uer_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .in_ready (in_ready),
    .q_full   (q_full),
    .rel_done (rel_done),
    .push     (push),
    .push_cmd (push_cmd),
    .wr       (wr)
  );

  uer_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  uer_back u_back (
    .clk        (clk),
    .rst        (rst),
    .wr         (wr),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .rel_done   (rel_done),
    .out_valid  (out_valid),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .out_ready  (out_ready)
  );

endmodule

[sim/testbench.sv]
module testbench;

  localparam int DirRows     = 8;
  localparam int RandItems   = 60;
  localparam int CalmItems   = 80;
  localparam int LongHold    = 300;
  localparam int LongHoldAt  = 150;
  localparam int StallLimit  = 3000;
  localparam int TailCycles  = 20;
  localparam int MaxFrame    = 128;

  // Header layout taken from the package
  localparam int unsigned            HdrBytes   = uer_pkg::HdrBytes;
  localparam int unsigned            PosW       = uer_pkg::PosW;
  localparam logic [PosW-1:0]        HdrFull    = uer_pkg::HdrFull;
  localparam int                     ProtoPos   = int'(uer_pkg::ProtoPos);
  localparam int                     IpSumPos   = int'(uer_pkg::IpSumPos);
  localparam int                     IpHdrFirst = int'(uer_pkg::IpHdrFirst);
  localparam int                     UdpSumPos  = int'(uer_pkg::UdpSumPos);
  localparam int                     TagPos     = int'(uer_pkg::TagPos);
  localparam logic [7:0]             ProtoUdp   = uer_pkg::ProtoUdp;
  localparam logic [31:0]            TagEcho    = uer_pkg::TagEcho;
  localparam logic [31:0]            TagHash    = uer_pkg::TagHash;
  localparam logic [31:0]            TagFlow    = uer_pkg::TagFlow;
  localparam logic [31:0]            TagSequ    = uer_pkg::TagSequ;

  // Header fields that the package gives no name to
  localparam int MacPeerPos  = 6;
  localparam int MacBytes    = 6;
  localparam int IpSrcPos    = 26;
  localparam int IpDstPos    = 30;
  localparam int PortSrcPos  = 34;
  localparam int PortDstPos  = 36;
  localparam int IpHdrWords  = 10;

  typedef enum logic [1:0] {
    FR_PLAIN,
    FR_ECHO,
    FR_BAD_TAG,
    FR_BAD_PROTO
  } frame_e;

  typedef enum logic [1:0] {
    FILL_RAND,
    FILL_ZERO,
    FILL_ONES
  } fill_e;

  typedef struct packed {
    logic [7:0]  len;
    frame_e      kind;
    logic [31:0] tag;
    fill_e       fill;
    logic        same;   // frame must leave the block unchanged
  } frame_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       same;
    logic       first;
    logic       pause;
  } stim_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } result_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       out_last;

  // Directed frames: extremes, each tag, near misses, short and exact-header lengths
  frame_row_t plan [DirRows] = '{
    '{8'd1,  FR_PLAIN,     TagEcho, FILL_ONES, 1'b1},
    '{8'd2,  FR_PLAIN,     TagEcho, FILL_ZERO, 1'b1},
    '{8'd45, FR_ECHO,      TagEcho, FILL_RAND, 1'b1},
    '{8'd46, FR_ECHO,      TagHash, FILL_ONES, 1'b0},
    '{8'd47, FR_ECHO,      TagFlow, FILL_ZERO, 1'b0},
    '{8'd48, FR_ECHO,      TagSequ, FILL_RAND, 1'b0},
    '{8'd46, FR_BAD_TAG,   TagEcho, FILL_RAND, 1'b1},
    '{8'd46, FR_BAD_PROTO, TagHash, FILL_RAND, 1'b1}
  };

  logic [31:0] known_tags [4] = '{TagEcho, TagHash, TagFlow, TagSequ};

  stim_item_t stim_q [$];
  result_t    reply_q [$];
  result_t    step_q [$];

  // Predictor state
  logic [7:0]      hdr_mem [HdrBytes];
  logic [PosW-1:0] hdr_fill;

  result_t want;
  bit      cur_same;
  bit      calm;
  bit      long_hold_pending;
  bit      moved;
  int      errors;
  int      in_count;
  int      out_count;
  int      idle_cycles;
  int      echo_frames;
  int      frames_built;

  udp_echo_reflector_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic swap_span(input int a, input int b, input int n);
    logic [7:0] t;
    for (int i = 0; i < n; i++) begin
      t = hdr_mem[a + i];
      hdr_mem[a + i] = hdr_mem[b + i];
      hdr_mem[b + i] = t;
    end
  endtask

  // Predict the bytes that leave the block for one accepted item
  task automatic reflect_byte(input logic [7:0] b, input logic l);
    logic [31:0]  tag;
    int unsigned  acc;
    step_q.delete();
    if (hdr_fill == HdrFull) begin
      // past the header: pass straight through
      step_q.push_back('{b, l});
      if (l) hdr_fill = '0;
    end else begin
      hdr_mem[hdr_fill] = b;
      hdr_fill = hdr_fill + 1'b1;
      if (hdr_fill == HdrFull) begin
        tag = {hdr_mem[TagPos], hdr_mem[TagPos + 1], hdr_mem[TagPos + 2], hdr_mem[TagPos + 3]};
        if (hdr_mem[ProtoPos] == ProtoUdp &&
            (tag == TagEcho || tag == TagHash || tag == TagFlow || tag == TagSequ)) begin
          echo_frames++;
          swap_span(0, MacPeerPos, MacBytes);
          swap_span(IpSrcPos, IpDstPos, 4);
          swap_span(PortSrcPos, PortDstPos, 2);
          // recompute the IP header checksum with its own field as zero
          hdr_mem[IpSumPos] = 8'h00;
          hdr_mem[IpSumPos + 1] = 8'h00;
          acc = 0;
          for (int w = 0; w < IpHdrWords; w++)
            acc += {hdr_mem[IpHdrFirst + 2 * w], hdr_mem[IpHdrFirst + 2 * w + 1]};
          acc = (acc >> 16) + (acc & 32'hffff);
          acc = acc + (acc >> 16);
          hdr_mem[IpSumPos] = ~acc[15:8];
          hdr_mem[IpSumPos + 1] = ~acc[7:0];
          hdr_mem[UdpSumPos] = 8'h00;
          hdr_mem[UdpSumPos + 1] = 8'h00;
        end
        for (int i = 0; i < HdrBytes; i++)
          step_q.push_back('{hdr_mem[i], l && i == HdrBytes - 1});
        if (l) hdr_fill = '0;
      end else if (l) begin
        // short frame: flush what is held
        for (int i = 0; i < hdr_fill; i++)
          step_q.push_back('{hdr_mem[i], i == hdr_fill - 1});
        hdr_fill = '0;
      end
    end
  endtask

  // Expand one frame description into byte items
  task automatic queue_frame(input frame_row_t r, input bit hold);
    logic [7:0] fbytes [MaxFrame];
    stim_item_t it;
    for (int i = 0; i < MaxFrame; i++) begin
      case (r.fill)
        FILL_ZERO: fbytes[i] = 8'h00;
        FILL_ONES: fbytes[i] = 8'hff;
        default:   fbytes[i] = 8'($urandom_range(255));
      endcase
    end
    case (r.kind)
      FR_ECHO: begin
        fbytes[ProtoPos] = ProtoUdp;
        {fbytes[TagPos], fbytes[TagPos + 1], fbytes[TagPos + 2], fbytes[TagPos + 3]} = r.tag;
      end
      FR_BAD_TAG: begin
        fbytes[ProtoPos] = ProtoUdp;
        {fbytes[TagPos], fbytes[TagPos + 1], fbytes[TagPos + 2], fbytes[TagPos + 3]} =
          r.tag ^ (32'h1 << $urandom_range(31));
      end
      FR_BAD_PROTO: begin
        fbytes[ProtoPos] = ProtoUdp ^ (8'h1 << $urandom_range(7));
        {fbytes[TagPos], fbytes[TagPos + 1], fbytes[TagPos + 2], fbytes[TagPos + 3]} = r.tag;
      end
      default: begin
        if (fbytes[ProtoPos] == ProtoUdp) fbytes[ProtoPos] = ~ProtoUdp;
      end
    endcase
    for (int i = 0; i < r.len; i++) begin
      it.data  = fbytes[i];
      it.last  = (i == r.len - 1);
      it.same  = r.same;
      it.first = (i == 0);
      it.pause = hold && i == 0;
      stim_q.push_back(it);
    end
    frames_built++;
  endtask

  task automatic flag_error(input string what, input result_t exp_r, input result_t act_r);
    errors++;
    if (errors <= 10)
      $display("ERROR %s at output byte %0d: expected %02h last %0b, got %02h last %0b",
               what, out_count, exp_r.data, exp_r.last, act_r.data, act_r.last);
  endtask

  // Check output items, predict accepted input items, watch for a hang
  always @(posedge clk) begin
    if (!rst) begin
      moved = 1'b0;
      if (out_valid && out_ready) begin
        moved = 1'b1;
        out_count++;
        if (reply_q.size() == 0) begin
          flag_error("unexpected byte", '0, '{out_byte, out_last});
        end else begin
          want = reply_q.pop_front();
          if (want.data !== out_byte || want.last !== out_last)
            flag_error("wrong byte", want, '{out_byte, out_last});
        end
      end
      if (in_valid && in_ready) begin
        moved = 1'b1;
        in_count++;
        reflect_byte(in_byte, in_last);
        if (cur_same) reply_q.push_back('{in_byte, in_last});
        else foreach (step_q[i]) reply_q.push_back(step_q[i]);
        if (in_count == LongHoldAt) long_hold_pending = 1'b1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("watchdog: nothing moved for %0d cycles, %0d bytes outstanding",
                 idle_cycles, reply_q.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Receiver: random stalls, one long hold-off, none at the end
  initial begin : sink
    int hold_left;
    int rx_pct;
    int tick;
    out_ready = 1'b0;
    hold_left = 0;
    rx_pct = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (tick % 64 == 0) begin
        case ($urandom_range(2))
          0:       rx_pct = 0;
          1:       rx_pct = 10;
          default: rx_pct = 30;
        endcase
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (long_hold_pending) begin
        hold_left = LongHold;
        long_hold_pending = 1'b0;
      end else if (!calm && $urandom_range(99) < rx_pct) begin
        hold_left = $urandom_range(1, 11);
      end
      out_ready <= !rst && hold_left == 0;
    end
  end

  // Sender: build the stimulus, reset, then offer every item
  initial begin : source
    frame_row_t r;
    stim_item_t it;
    int         gap;
    int         tx_pct;
    int         rand_bytes;
    int         pick;
    rst = 1'b1;
    in_valid = 1'b0;
    in_byte = 8'h00;
    in_last = 1'b0;
    cur_same = 1'b0;
    calm = 1'b0;
    long_hold_pending = 1'b0;
    hdr_fill = '0;
    errors = 0;
    in_count = 0;
    out_count = 0;
    idle_cycles = 0;
    echo_frames = 0;
    frames_built = 0;
    tx_pct = 0;
    rand_bytes = 0;

    foreach (plan[i]) queue_frame(plan[i], i == DirRows / 2);

    // Mostly well-formed echo frames, the rest near misses and noise
    while (rand_bytes < RandItems) begin
      pick = $urandom_range(99);
      r.same = 1'b0;
      r.tag = known_tags[$urandom_range(3)];
      case ($urandom_range(19))
        0:       r.fill = FILL_ONES;
        1:       r.fill = FILL_ZERO;
        default: r.fill = FILL_RAND;
      endcase
      if (pick < 55) begin
        r.kind = FR_ECHO;
        r.len = ($urandom_range(4) == 0) ? 8'($urandom_range(53, 90))
                                         : 8'($urandom_range(46, 52));
      end else if (pick < 65) begin
        r.kind = FR_BAD_TAG;
        r.len = 8'($urandom_range(46, 60));
      end else if (pick < 75) begin
        r.kind = FR_BAD_PROTO;
        r.len = 8'($urandom_range(46, 60));
      end else begin
        r.kind = FR_PLAIN;
        r.len = 8'($urandom_range(1, 60));
      end
      queue_frame(r, rand_bytes == 0);
      rand_bytes += r.len;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int k = 0; k < stim_q.size(); k++) begin
      it = stim_q[k];
      if (k >= stim_q.size() - CalmItems) calm = 1'b1;
      if (it.first) begin
        case ($urandom_range(2))
          0:       tx_pct = 0;
          1:       tx_pct = 10;
          default: tx_pct = 35;
        endcase
      end
      // drain the block before this frame
      if (it.pause) begin
        @(negedge clk);
        in_valid <= 1'b0;
        wait (reply_q.size() == 0);
      end
      gap = (!calm && $urandom_range(99) < tx_pct) ? $urandom_range(1, 11) : 0;
      @(negedge clk);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid <= 1'b1;
      in_byte  <= it.data;
      in_last  <= it.last;
      cur_same = it.same;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    wait (reply_q.size() == 0);
    repeat (TailCycles) @(posedge clk);

    $display("Sent %0d frames (%0d bytes), %0d of them rewritten as echo replies.",
             frames_built, in_count, echo_frames);
    $display("Checked %0d output bytes under random stalls and one long receiver hold-off.",
             out_count);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/uer_pkg.sv
rtl/uer_front.sv
rtl/uer_queue.sv
rtl/uer_back.sv
rtl/udp_echo_reflector_top.sv
sim/testbench.sv
